// File: sv/block_peak_auto_gain_assert.svh
// Assertion macros shared by the peak auto gain RTL.
`ifndef BLOCK_PEAK_AUTO_GAIN_ASSERT_SVH
`define BLOCK_PEAK_AUTO_GAIN_ASSERT_SVH

// Plain property, checked outside reset.
`define BPAG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Overlapping implication, checked outside reset.
`define BPAG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: sv/bpag_pkg.sv
// Types and constants of the peak auto gain block.
package bpag_pkg;

    localparam int unsigned  DIV_BITS     = 28;
    localparam int unsigned  DIV_CNT_W    = $clog2(DIV_BITS);
    localparam logic [15:0]  UNITY_GAIN   = 16'd2048;
    localparam logic [15:0]  MAX_GAIN_Q11 = 16'd32768;
    localparam logic [15:0]  ENV_FULL     = 16'h8000;
    localparam logic [32:0]  ROUND_HALF   = 33'd32768;

    typedef enum logic [3:0] {
        REG_ATTACK_COEF  = 4'd0,
        REG_RELEASE_COEF = 4'd1,
        REG_SMOOTH_COEF  = 4'd2,
        REG_AUTO_MODE    = 4'd3,
        REG_MANUAL_GAIN  = 4'd4,
        REG_TARGET_LEVEL = 4'd5,
        REG_FLOOR_LEVEL  = 4'd6,
        REG_BYPASS       = 4'd7
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENV_MUL,
        S_ENV_UPD,
        S_CHECK,
        S_DIV,
        S_CAP,
        S_GAIN_MUL,
        S_GAIN_UPD,
        S_OUT
    } t_back_state;

    typedef struct packed {
        logic [15:0] attack_coef;
        logic [15:0] release_coef;
        logic [15:0] smooth_coef;
        logic        auto_mode;
        logic [15:0] manual_gain;
        logic [15:0] target_level;
        logic [15:0] floor_level;
        logic        bypass;
    } t_cfg;

    typedef struct packed {
        logic        push;
        logic [15:0] peak;
    } t_job_push;

endpackage

// File: sv/bpag_front.sv
// Front end: sample magnitude, running block peak, block-end job push.
module bpag_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic signed [15:0]    i_sample_left,
    input  logic signed [15:0]    i_sample_right,
    input  logic                  i_block_end,
    input  logic                  i_bypass,
    input  logic                  i_q_full,
    output bpag_pkg::t_job_push   o_job
);

    logic [15:0] r_peak;
    logic [15:0] n_peak;
    logic [15:0] abs_l;
    logic [15:0] abs_r;
    logic [15:0] max_lr;
    logic [15:0] blk_max;
    logic        take;

    // two's complement magnitude; -32768 maps to 0x8000 = 32768
    assign abs_l  = i_sample_left[15]  ? (~i_sample_left  + 16'd1) : i_sample_left;
    assign abs_r  = i_sample_right[15] ? (~i_sample_right + 16'd1) : i_sample_right;
    assign max_lr = (abs_l > abs_r) ? abs_l : abs_r;
    assign blk_max = (max_lr > r_peak) ? max_lr : r_peak;

    assign o_in_stall = i_q_full;
    assign take       = i_in_valid && !o_in_stall && !i_bypass;

    always_comb begin
        n_peak        = r_peak;
        o_job.push    = 1'b0;
        o_job.peak    = blk_max;
        if (take) begin
            if (i_block_end) begin
                o_job.push = 1'b1;
                n_peak     = 16'd0;
            end else begin
                n_peak     = blk_max;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= 16'd0;
        end else begin
            r_peak <= n_peak;
        end
    end

endmodule

// File: sv/bpag_queue.sv
// Two-entry show-ahead queue of block peaks between front and back.
`include "block_peak_auto_gain_assert.svh"

module bpag_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bpag_pkg::t_job_push  i_job,
    output logic                 o_full,
    output logic                 o_valid,
    output logic [15:0]          o_peak,
    input  logic                 i_pop
);

    logic [15:0] r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_peak  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_job.push) begin
            r_mem[r_wr_ptr] <= i_job.peak;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_job.push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_job.push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_job.push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    `BPAG_ASSERT_IMPL(a_no_push_full, i_clk, i_rst_n, i_job.push, !o_full, "push into full queue")
    `BPAG_ASSERT_IMPL(a_no_pop_empty, i_clk, i_rst_n, i_pop, o_valid, "pop from empty queue")

endmodule

// File: sv/bpag_back.sv
// Back end: envelope update, gain divide, gain smoothing and result register.
`include "block_peak_auto_gain_assert.svh"

module bpag_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bpag_pkg::t_cfg      i_cfg,
    input  logic                i_job_valid,
    input  logic [15:0]         i_job_peak,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [15:0]         o_detect_gain,
    output logic [15:0]         o_envelope_level
);

    bpag_pkg::t_back_state r_state;
    bpag_pkg::t_back_state n_state;

    logic [15:0] r_peak;
    logic [15:0] r_env;
    logic [15:0] r_gain;
    logic [15:0] r_desired;
    logic [15:0] r_res_gain;
    logic        r_up;
    logic [31:0] r_prod;
    logic [bpag_pkg::DIV_BITS-1:0]  r_num;
    logic [16:0] r_rem;
    logic [bpag_pkg::DIV_CNT_W-1:0] r_cnt;
    logic        r_out_valid;
    logic [15:0] r_out_gain;
    logic [15:0] r_out_env;

    logic        out_load;
    logic [15:0] m_coef;
    logic [16:0] m_diff;
    logic        m_up;
    logic [32:0] m_prod;
    logic [32:0] rounded;
    logic [16:0] step;
    logic [16:0] env_sum;
    logic [16:0] gain_sum;
    logic [16:0] rem_sh;
    logic        q_bit;
    logic [16:0] rem_new;
    logic        env_above;
    logic [bpag_pkg::DIV_BITS-1:0] num_init;
    logic [15:0] q_cap;

    assign out_load = !r_out_valid || !i_out_stall;

    // one shared 16x17 multiplier for both smoothing steps
    always_comb begin
        m_coef = 16'd0;
        m_diff = 17'd0;
        m_up   = 1'b1;
        case (r_state)
            bpag_pkg::S_ENV_MUL: begin
                m_coef = (r_peak > r_env) ? i_cfg.attack_coef : i_cfg.release_coef;
                m_up   = (r_peak >= r_env);
                m_diff = m_up ? 17'(r_peak - r_env) : 17'(r_env - r_peak);
            end
            bpag_pkg::S_GAIN_MUL: begin
                m_coef = i_cfg.smooth_coef;
                m_up   = (r_desired >= r_gain);
                m_diff = m_up ? 17'(r_desired - r_gain) : 17'(r_gain - r_desired);
            end
            default: begin
                m_coef = 16'd0;
            end
        endcase
    end

    assign m_prod   = 33'(m_coef) * m_diff;
    // round to nearest, ties away from zero, on the magnitude
    assign rounded  = {1'b0, r_prod} + bpag_pkg::ROUND_HALF;
    assign step     = rounded[32:16];
    assign env_sum  = r_up ? (17'(r_env) + step) : (17'(r_env) - step);
    assign gain_sum = r_up ? (17'(r_gain) + step) : (17'(r_gain) - step);

    // restoring divider, one quotient bit per cycle
    assign rem_sh  = {r_rem[15:0], r_num[bpag_pkg::DIV_BITS-1]};
    assign q_bit   = (rem_sh >= {1'b0, r_env});
    assign rem_new = q_bit ? (rem_sh - {1'b0, r_env}) : rem_sh;

    assign env_above = (r_env > i_cfg.floor_level) && (r_env != 16'd0);
    assign num_init  = bpag_pkg::DIV_BITS'({i_cfg.target_level, 11'd0})
                     + bpag_pkg::DIV_BITS'(r_env[15:1]);
    assign q_cap     = (r_num > bpag_pkg::DIV_BITS'(bpag_pkg::MAX_GAIN_Q11))
                     ? bpag_pkg::MAX_GAIN_Q11 : r_num[15:0];

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        unique case (r_state)
            bpag_pkg::S_IDLE: begin
                if (i_job_valid) begin
                    o_pop   = 1'b1;
                    n_state = i_cfg.auto_mode ? bpag_pkg::S_ENV_MUL : bpag_pkg::S_OUT;
                end
            end
            bpag_pkg::S_ENV_MUL:  n_state = bpag_pkg::S_ENV_UPD;
            bpag_pkg::S_ENV_UPD:  n_state = bpag_pkg::S_CHECK;
            bpag_pkg::S_CHECK: begin
                n_state = env_above ? bpag_pkg::S_DIV : bpag_pkg::S_GAIN_MUL;
            end
            bpag_pkg::S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = bpag_pkg::S_CAP;
                end
            end
            bpag_pkg::S_CAP:      n_state = bpag_pkg::S_GAIN_MUL;
            bpag_pkg::S_GAIN_MUL: n_state = bpag_pkg::S_GAIN_UPD;
            bpag_pkg::S_GAIN_UPD: n_state = bpag_pkg::S_OUT;
            bpag_pkg::S_OUT: begin
                if (out_load) begin
                    n_state = bpag_pkg::S_IDLE;
                end
            end
            default:              n_state = bpag_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpag_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // block state: envelope and gain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env  <= 16'd0;
            r_gain <= bpag_pkg::UNITY_GAIN;
        end else begin
            if (r_state == bpag_pkg::S_IDLE && i_job_valid && !i_cfg.auto_mode) begin
                r_env  <= 16'd0;
                r_gain <= bpag_pkg::UNITY_GAIN;
            end
            if (r_state == bpag_pkg::S_ENV_UPD) begin
                r_env <= env_sum[15:0];
            end
            if (r_state == bpag_pkg::S_GAIN_UPD) begin
                r_gain <= gain_sum[15:0];
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            bpag_pkg::S_IDLE: begin
                r_peak     <= i_job_peak;
                r_res_gain <= i_cfg.manual_gain;
            end
            bpag_pkg::S_ENV_MUL, bpag_pkg::S_GAIN_MUL: begin
                r_prod <= m_prod[31:0];
                r_up   <= m_up;
            end
            bpag_pkg::S_CHECK: begin
                r_desired <= r_gain;
                r_num     <= num_init;
                r_rem     <= 17'd0;
                r_cnt     <= bpag_pkg::DIV_CNT_W'(bpag_pkg::DIV_BITS - 1);
            end
            bpag_pkg::S_DIV: begin
                r_num <= {r_num[bpag_pkg::DIV_BITS-2:0], q_bit};
                r_rem <= rem_new;
                r_cnt <= r_cnt - 1'b1;
            end
            bpag_pkg::S_CAP: begin
                r_desired <= q_cap;
            end
            bpag_pkg::S_GAIN_UPD: begin
                r_res_gain <= gain_sum[15:0];
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == bpag_pkg::S_OUT && out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == bpag_pkg::S_OUT && out_load) begin
            r_out_gain <= r_res_gain;
            r_out_env  <= r_env;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_detect_gain    = r_out_gain;
    assign o_envelope_level = r_out_env;

    `BPAG_ASSERT_IMPL(a_div_nonzero, i_clk, i_rst_n, r_state == bpag_pkg::S_DIV, r_env != 16'd0, "divide by zero envelope")
    `BPAG_ASSERT(a_env_range, i_clk, i_rst_n, r_env <= bpag_pkg::ENV_FULL, "envelope above full scale")
    `BPAG_ASSERT(a_out_issue, i_clk, i_rst_n, (r_state == bpag_pkg::S_OUT && !r_out_valid) |=> r_out_valid, "result not issued")

endmodule

// File: sv/block_peak_auto_gain.sv
// Top level of the peak-envelope automatic gain control block.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------------
//  in      | sink      | i_in_valid/o_in_stall  | i_sample_left, i_sample_right,
//          |           |                        | i_block_end
//  out     | source    | o_out_valid/i_out_stall| o_detect_gain, o_envelope_level
//  cfg     | sink      | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// A sample request is taken every cycle; the front stalls only when two
// block-end jobs already wait in the queue.
// Manual mode resets envelope and gain and issues the manual gain; auto mode
// smooths both, dividing (28 steps, one quotient bit a cycle) above the floor.
// Reset is synchronous, active low; it clears peak, envelope (0), gain (unity), the queue,
// the state and the configuration; data registers are not reset. No clearing pass.
// A stalled result sits in the output register while the back end works on.
module block_peak_auto_gain (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // sample channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_sample_left,
    input  logic signed [15:0] i_sample_right,
    input  logic               i_block_end,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [15:0]        o_detect_gain,
    output logic [15:0]        o_envelope_level,
    // configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    bpag_pkg::t_cfg      r_cfg;
    bpag_pkg::t_job_push job;
    logic                q_full;
    logic                q_valid;
    logic [15:0]         q_peak;
    logic                q_pop;

    // registers take writes at any time; software writes only while idle
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_coef  <= 16'd65535;
            r_cfg.release_coef <= 16'd1000;
            r_cfg.smooth_coef  <= 16'd8000;
            r_cfg.auto_mode    <= 1'b0;
            r_cfg.manual_gain  <= 16'd2048;
            r_cfg.target_level <= 16'd8192;
            r_cfg.floor_level  <= 16'd33;
            r_cfg.bypass       <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (bpag_pkg::t_reg_idx'(i_cfg_index))
                bpag_pkg::REG_ATTACK_COEF:  r_cfg.attack_coef  <= i_cfg_data;
                bpag_pkg::REG_RELEASE_COEF: r_cfg.release_coef <= i_cfg_data;
                bpag_pkg::REG_SMOOTH_COEF:  r_cfg.smooth_coef  <= i_cfg_data;
                bpag_pkg::REG_AUTO_MODE:    r_cfg.auto_mode    <= i_cfg_data[0];
                bpag_pkg::REG_MANUAL_GAIN:  r_cfg.manual_gain  <= i_cfg_data;
                bpag_pkg::REG_TARGET_LEVEL: r_cfg.target_level <= i_cfg_data;
                bpag_pkg::REG_FLOOR_LEVEL:  r_cfg.floor_level  <= i_cfg_data;
                bpag_pkg::REG_BYPASS:       r_cfg.bypass       <= i_cfg_data[0];
                default:                    r_cfg <= r_cfg;   // unmapped index
            endcase
        end
    end

    // front: magnitude and block peak; bypass requests are taken and dropped
    bpag_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample_left  (i_sample_left),
        .i_sample_right (i_sample_right),
        .i_block_end    (i_block_end),
        .i_bypass       (r_cfg.bypass),
        .i_q_full       (q_full),
        .o_job          (job)
    );

    // block peaks waiting for the back end
    bpag_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_peak  (q_peak),
        .i_pop   (q_pop)
    );

    // back: envelope, divide, smoothing, result register
    bpag_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_job_valid      (q_valid),
        .i_job_peak       (q_peak),
        .o_pop            (q_pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_detect_gain    (o_detect_gain),
        .o_envelope_level (o_envelope_level)
    );

endmodule
